// ===== src/dtq_pkg.sv =====
// Package: shared types and constants for the delta timer queue.
`timescale 1ns / 1ps
package dtq_pkg;
  localparam int ENTRIES   = 16;
  localparam int TIME_BITS = 32;
  localparam int IDW       = $clog2(ENTRIES);
  localparam int LNKW      = IDW + 1;
  localparam logic [LNKW-1:0] NIL = LNKW'(ENTRIES);
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    OP_SCHED    = 3'd0,
    OP_SHIFT    = 3'd1,
    OP_POP      = 3'd2,
    OP_POP_RESC = 3'd3,
    OP_RESCHED  = 3'd4,
    OP_REMOVE   = 3'd5,
    OP_NOP6     = 3'd6,
    OP_NOP7     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_QUEUED = 2'd1,
    ST_QUEUED     = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  entry_id;
    logic [31:0] time_value;
  } in_beat_t;

  typedef struct packed {
    status_t    status;
    logic       popped_valid;
    logic [3:0] popped_id;
    logic       queue_empty;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_UNL_WALK,
    S_UNL_FIX,
    S_INS_WALK,
    S_INS_LINK,
    S_INS_PATCH,
    S_SH_WALK,
    S_DONE
  } state_t;

  // Shared subtract/compare unit command and result.
  typedef struct packed {
    logic [TIME_BITS-1:0] a;
    logic [TIME_BITS-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                 a_le_b;   // a <= b
    logic [TIME_BITS-1:0] b_sub_a;  // b - a
    logic [TIME_BITS-1:0] a_sub_b;  // a - b
    logic [TIME_BITS-1:0] sat_sum;  // a + b, saturated
  } alu_rsp_t;
endpackage

// ===== src/dtq_alu.sv =====
// Shared compare, subtract and saturating add unit.
`timescale 1ns / 1ps
module dtq_alu (
  input  dtq_pkg::alu_req_t req,
  output dtq_pkg::alu_rsp_t rsp
);
  import dtq_pkg::*;
  logic [TIME_BITS:0] sum;
  assign sum         = {1'b0, req.a} + {1'b0, req.b};
  assign rsp.a_le_b  = req.a <= req.b;
  assign rsp.b_sub_a = req.b - req.a;
  assign rsp.a_sub_b = req.a - req.b;
  assign rsp.sat_sum = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
endmodule

// ===== src/delta_timer_queue.sv =====
// Top level: delta timer queue sequencer with linked-list storage.
`timescale 1ns / 1ps
//  channel | direction | beat         | handshake
//  in_     | input     | in_beat_t    | in_valid / in_stall
//  out_    | output    | out_beat_t   | out_valid / out_stall
// One beat per operation. The list walks (remove, shift, schedule,
// pop_reschedule, and for reschedule an unlink walk then an insert walk)
// visit one entry per cycle through the shared subtract unit, and the
// sequencer returns to idle before the next beat is taken.
// Reset empties the queue at once (flags cleared, head set to none).
// in_stall is high from acceptance until the sequencer is idle again.
// out_stall holds the result register; the next op runs meanwhile and waits
// in the done state until the held beat goes.
module delta_timer_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtq_pkg::out_beat_t out_data
);
  import dtq_pkg::*;

  // Entry stores: undefined until written, only read for queued entries.
  logic [TIME_BITS-1:0] delta_mem [ENTRIES];
  logic [LNKW-1:0]      link_mem  [ENTRIES];
  logic [ENTRIES-1:0]   queued_r, queued_nxt;
  logic [LNKW-1:0]      head_r, head_nxt;

  state_t               state_r, state_nxt;
  opcode_t              op_r, op_nxt;
  logic [IDW-1:0]       id_r, id_nxt;
  logic [TIME_BITS-1:0] tv_r, tv_nxt;       // remaining delay / time
  logic [LNKW-1:0]      prev_r, prev_nxt;
  logic [LNKW-1:0]      cur_r, cur_nxt;
  logic [IDW:0]         guard_r, guard_nxt;
  out_beat_t            wres_r, wres_nxt;   // result under construction
  out_beat_t            res_r, res_nxt;     // result on the out_ channel
  logic                 ov_r, ov_nxt;

  // Store write ports, one delta write and one link write per cycle.
  logic                 dw_en;
  logic [IDW-1:0]       dw_addr;
  logic [TIME_BITS-1:0] dw_data;
  logic                 lw_en;
  logic [IDW-1:0]       lw_addr;
  logic [LNKW-1:0]      lw_data;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  dtq_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  logic [IDW-1:0]       cur_i, in_id;
  logic [TIME_BITS-1:0] cur_d;
  logic [LNKW-1:0]      cur_l;
  logic                 cur_nil;
  assign cur_i   = cur_r[IDW-1:0];
  assign cur_nil = cur_r[IDW];
  assign cur_d   = delta_mem[cur_i];
  assign cur_l   = link_mem[cur_i];
  assign in_id   = in_data.entry_id[IDW-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      queued_r <= '0;
      head_r   <= NIL;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      queued_r <= queued_nxt;
      head_r   <= head_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    id_r    <= id_nxt;
    tv_r    <= tv_nxt;
    prev_r  <= prev_nxt;
    cur_r   <= cur_nxt;
    guard_r <= guard_nxt;
    wres_r  <= wres_nxt;
    res_r   <= res_nxt;
    if (dw_en) begin
      delta_mem[dw_addr] <= dw_data;
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    queued_nxt = queued_r;
    head_nxt   = head_r;
    ov_nxt     = ov_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    tv_nxt     = tv_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    guard_nxt  = guard_r;
    wres_nxt   = wres_r;
    res_nxt    = res_r;
    dw_en      = 1'b0;
    dw_addr    = cur_i;
    dw_data    = '0;
    lw_en      = 1'b0;
    lw_addr    = cur_i;
    lw_data    = NIL;
    alu_req.a  = cur_d;
    alu_req.b  = tv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          id_nxt    = in_id;
          tv_nxt    = in_data.time_value[TIME_BITS-1:0];
          wres_nxt  = '0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        prev_nxt  = NIL;
        cur_nxt   = head_r;
        guard_nxt = '0;
        state_nxt = S_DONE;
        case (op_r)
          OP_SCHED: begin
            if (queued_r[id_r]) wres_nxt.status = ST_QUEUED;
            else state_nxt = S_INS_WALK;
          end
          OP_SHIFT: state_nxt = S_SH_WALK;
          OP_POP, OP_POP_RESC: state_nxt = S_POP;
          OP_RESCHED, OP_REMOVE: begin
            if (!queued_r[id_r]) wres_nxt.status = ST_NOT_QUEUED;
            else state_nxt = S_UNL_WALK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_POP: begin
        // cur_r holds the head here
        state_nxt = S_DONE;
        if (!cur_nil && cur_d == '0) begin
          wres_nxt.popped_valid = 1'b1;
          wres_nxt.popped_id    = 4'(cur_i);
          head_nxt              = cur_l;
          queued_nxt[cur_i]     = 1'b0;
          lw_en                 = 1'b1;
          lw_data               = NIL;
          if (op_r == OP_POP_RESC) begin
            id_nxt    = cur_i;
            cur_nxt   = cur_l;
            state_nxt = S_INS_WALK;
          end
        end
      end
      S_UNL_WALK: begin
        if (cur_nil || guard_r == (IDW+1)'(ENTRIES)) begin
          queued_nxt[id_r] = 1'b0;
          state_nxt        = (op_r == OP_RESCHED) ? S_UNL_FIX : S_DONE;
        end else if (cur_i == id_r) begin
          if (prev_r[IDW]) head_nxt = cur_l;
          else begin
            lw_en   = 1'b1;
            lw_addr = prev_r[IDW-1:0];
            lw_data = cur_l;
          end
          queued_nxt[id_r] = 1'b0;
          prev_nxt = cur_r;      // remember the removed entry
          cur_nxt  = cur_l;      // successor to receive the delay
          state_nxt = S_UNL_FIX;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = cur_l;
          guard_nxt = guard_r + 1'b1;
        end
      end
      S_UNL_FIX: begin
        // successor += removed delay, saturating
        if (!prev_r[IDW] && prev_r[IDW-1:0] == id_r) begin
          alu_req.a = delta_mem[id_r];
          alu_req.b = cur_d;
          if (!cur_nil) begin
            dw_en   = 1'b1;
            dw_data = alu_rsp.sat_sum;
          end
          lw_en   = 1'b1;
          lw_addr = id_r;
          lw_data = NIL;
        end
        if (op_r == OP_RESCHED) begin
          prev_nxt  = NIL;
          cur_nxt   = head_nxt;
          guard_nxt = '0;
          state_nxt = S_INS_WALK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_WALK: begin
        if (cur_nil || guard_r == (IDW+1)'(ENTRIES)) begin
          state_nxt = S_INS_LINK;
        end else if (alu_rsp.a_le_b) begin
          tv_nxt    = alu_rsp.b_sub_a;
          prev_nxt  = cur_r;
          cur_nxt   = cur_l;
          guard_nxt = guard_r + 1'b1;
        end else begin
          dw_en     = 1'b1;
          dw_data   = alu_rsp.a_sub_b;
          state_nxt = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        // new entry takes its delay and the successor found by the walk
        dw_en   = 1'b1;
        dw_addr = id_r;
        dw_data = tv_r;
        lw_en   = 1'b1;
        lw_addr = id_r;
        lw_data = cur_r;
        if (prev_r[IDW]) head_nxt = {1'b0, id_r};
        queued_nxt[id_r] = 1'b1;
        state_nxt = (prev_r[IDW]) ? S_DONE : S_INS_PATCH;
      end
      S_INS_PATCH: begin
        // predecessor now points at the new entry
        lw_en     = 1'b1;
        lw_addr   = prev_r[IDW-1:0];
        lw_data   = {1'b0, id_r};
        state_nxt = S_DONE;
      end
      S_SH_WALK: begin
        if (cur_nil || guard_r == (IDW+1)'(ENTRIES)) begin
          state_nxt = S_DONE;
        end else if (alu_rsp.a_le_b) begin
          tv_nxt    = alu_rsp.b_sub_a;
          dw_en     = 1'b1;
          dw_data   = '0;
          cur_nxt   = cur_l;
          guard_nxt = guard_r + 1'b1;
        end else begin
          dw_en     = 1'b1;
          dw_data   = alu_rsp.a_sub_b;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          res_nxt             = wres_r;
          res_nxt.queue_empty = head_r[IDW];
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ov_r && !out_stall && !(state_r == S_DONE)) ov_nxt = 1'b0;
  end

  // Queue empty flag must agree with head on every result.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(ov_r && out_stall)) |=> res_r.queue_empty == head_r[IDW])
    else $error("queue_empty mismatch");
  a_pop_id: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && res_r.popped_valid) |-> (res_r.status == ST_OK))
    else $error("pop with bad status");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("accept while busy");
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) |-> (queued_r == '0 || state_r != S_IDLE))
    else $error("empty head with queued entries");
endmodule
